### hdl/fpsl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpsl_pkg
// Shared types and constants of the passive serial configuration loader.
// ---------------------------------------------------------------------------
package fpsl_pkg;

    localparam int LEN_W       = 25;
    localparam int TRAIL_W     = 6;
    localparam int STEP_W      = 6;
    localparam int CFG_DATA_W  = 25;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam logic [TRAIL_W-1:0] MAX_TRAIL     = 6'd32;
    localparam logic [LEN_W-1:0]   LEN_RESET     = 25'd163840;
    localparam logic [TRAIL_W-1:0] TRAIL_RESET   = 6'd19;
    localparam logic [STEP_W-1:0]  BITS_PER_BYTE = 6'd8;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_LENGTH    = 1'b0;
    localparam logic CFG_TRAILING_CLOCKS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_POLL  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_LOAD  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERROR = 3'd4,
        PH_ENDED = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_WORKING = 3'd0,
        ST_WAITING = 3'd1,
        ST_ERROR   = 3'd2,
        ST_DONE    = 3'd3,
        ST_ENDED   = 3'd4,
        ST_REJECT  = 3'd5
    } load_status_t;

    // Kind of pin sequence the back end has to play.
    typedef enum logic [1:0] {
        CMD_SINGLE = 2'd0,
        CMD_PULSE  = 2'd1,
        CMD_SHIFT  = 2'd2
    } cmd_kind_t;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [7:0]           data_byte;
        logic                 held_bit;
        load_status_t         final_status;
        logic [TRAIL_W-1:0]   trail;
    } cmd_t;

    // One result on the pins.
    typedef struct packed {
        logic         reset_line;
        logic         clock_pulse;
        logic         data_bit;
        load_status_t load_status;
        logic         last;
    } result_t;

endpackage

### hdl/fpsl_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpsl_front
// Accepts input items, tracks the load phase and turns each item into a
// pin sequence command for the back end.
// ---------------------------------------------------------------------------
module fpsl_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [fpsl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic                           pulse_reset,
    input  logic [7:0]                     data_byte,
    input  logic                           status_pin,
    input  logic                           done_pin,
    input  logic                           q_full,
    output logic                           q_push,
    output fpsl_pkg::cmd_t                 q_cmd
);
    import fpsl_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    bytes_sent_reg, bytes_sent_next;
    logic                held_bit_reg, held_bit_next;
    logic [LEN_W-1:0]    image_length_reg;
    logic [TRAIL_W-1:0]  trailing_clocks_reg;
    logic [LEN_W-1:0]    limit;
    logic [LEN_W-1:0]    sent_inc;
    logic [TRAIL_W-1:0]  trail_sat;
    logic                accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg    <= LEN_RESET;
            trailing_clocks_reg <= TRAIL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_IMAGE_LENGTH)
                image_length_reg <= cfg_wdata[LEN_W-1:0];
            else
                trailing_clocks_reg <= cfg_wdata[TRAIL_W-1:0];
        end
    end

    // Phase and load counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_sent_reg <= '0;
            held_bit_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_sent_reg <= bytes_sent_next;
            held_bit_reg   <= held_bit_next;
        end
    end

    // A zero length acts as one; the trailing count saturates.
    assign limit     = (image_length_reg == '0) ? LEN_W'(1) : image_length_reg;
    assign sent_inc  = bytes_sent_reg + LEN_W'(1);
    assign trail_sat = (trailing_clocks_reg > MAX_TRAIL) ? MAX_TRAIL : trailing_clocks_reg;

    // Classify the item against the current phase.
    always_comb
    begin
        phase_next         = phase_reg;
        bytes_sent_next    = bytes_sent_reg;
        held_bit_next      = held_bit_reg;
        q_cmd.kind         = CMD_SINGLE;
        q_cmd.data_byte    = data_byte;
        q_cmd.held_bit     = held_bit_reg;
        q_cmd.final_status = ST_REJECT;
        q_cmd.trail        = '0;
        if (accept)
        begin
            case (func_t'(func))
                FUNC_START:
                begin
                    bytes_sent_next = '0;
                    if (pulse_reset)
                    begin
                        q_cmd.kind = CMD_PULSE;
                        if (status_pin)
                        begin
                            phase_next         = PH_LOAD;
                            q_cmd.final_status = ST_WORKING;
                        end
                        else
                        begin
                            phase_next         = PH_WAIT;
                            q_cmd.final_status = ST_WAITING;
                        end
                    end
                    else
                    begin
                        phase_next         = PH_LOAD;
                        q_cmd.final_status = ST_WORKING;
                    end
                end
                FUNC_POLL:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (status_pin)
                        begin
                            phase_next         = PH_LOAD;
                            q_cmd.final_status = ST_WORKING;
                        end
                        else
                        begin
                            q_cmd.final_status = ST_WAITING;
                        end
                    end
                end
                FUNC_BYTE:
                begin
                    if (phase_reg == PH_LOAD)
                    begin
                        q_cmd.kind         = CMD_SHIFT;
                        q_cmd.final_status = ST_WORKING;
                        bytes_sent_next    = sent_inc;
                        held_bit_next      = data_byte[7];
                        if (!status_pin)
                        begin
                            phase_next         = PH_ERROR;
                            q_cmd.final_status = ST_ERROR;
                        end
                        else if (done_pin)
                        begin
                            phase_next         = PH_DONE;
                            q_cmd.final_status = ST_DONE;
                            q_cmd.trail        = trail_sat;
                        end
                        else if (sent_inc >= limit)
                        begin
                            phase_next         = PH_ENDED;
                            q_cmd.final_status = ST_ENDED;
                        end
                    end
                end
                default:
                begin
                    q_cmd.final_status = ST_REJECT;
                end
            endcase
        end
    end

endmodule

### hdl/fpsl_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpsl_queue
// Two-entry command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module fpsl_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpsl_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output fpsl_pkg::cmd_t head_cmd
);
    import fpsl_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/fpsl_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpsl_back
// Plays each command as a run of pin results, one per cycle while the output is not stalled,
// into an output register.
// ---------------------------------------------------------------------------
module fpsl_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  fpsl_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output fpsl_pkg::result_t out_result
);
    import fpsl_pkg::*;

    cmd_t               cmd_reg, cmd_next;
    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               valid_reg, valid_next;
    result_t            result_reg, result_next;
    result_t            cur;
    logic [STEP_W-1:0]  end_step;
    logic               advance;
    logic               is_last;

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Index of the final result of the current command.
    always_comb
    begin
        case (cmd_reg.kind)
            CMD_PULSE: end_step = STEP_W'(1);
            CMD_SHIFT: end_step = BITS_PER_BYTE - STEP_W'(1) + cmd_reg.trail;
            default:   end_step = '0;
        endcase
    end

    assign advance = busy_reg && (!valid_reg || out_ready);
    assign is_last = (step_reg == end_step);
    assign q_pop   = q_valid && (!busy_reg || (advance && is_last));

    // Result for the current step.
    always_comb
    begin
        cur.reset_line  = 1'b1;
        cur.clock_pulse = 1'b0;
        cur.data_bit    = cmd_reg.held_bit;
        cur.load_status = cmd_reg.final_status;
        cur.last        = is_last;
        case (cmd_reg.kind)
            CMD_PULSE:
            begin
                if (step_reg == '0)
                begin
                    cur.reset_line  = 1'b0;
                    cur.load_status = ST_WORKING;
                end
            end
            CMD_SHIFT:
            begin
                cur.clock_pulse = 1'b1;
                if (step_reg < BITS_PER_BYTE)
                    cur.data_bit = cmd_reg.data_byte[step_reg[2:0]];
                else
                    cur.data_bit = cmd_reg.data_byte[7];
                if (step_reg < BITS_PER_BYTE - STEP_W'(1))
                    cur.load_status = ST_WORKING;
                else if (step_reg >= BITS_PER_BYTE)
                    cur.load_status = ST_DONE;
            end
            default:
            begin
                cur.reset_line = 1'b1;
            end
        endcase
    end

    // Sequencer and output register.
    always_comb
    begin
        cmd_next    = cmd_reg;
        busy_next   = busy_reg;
        step_next   = step_reg;
        valid_next  = valid_reg && !out_ready;
        result_next = result_reg;
        if (advance)
        begin
            valid_next  = 1'b1;
            result_next = cur;
            step_next   = step_reg + STEP_W'(1);
            if (is_last)
                busy_next = 1'b0;
        end
        if (q_pop)
        begin
            cmd_next  = q_cmd;
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

endmodule

### hdl/fpga_passive_serial_loader_top.sv
`timescale 1ns / 1ps
// The first result of an item passes through a queue entry, the back end's command register
// and output register. The back end sends one result per cycle unless the output stalls:
// eight per image byte plus trailing clocks after done, one or two per start, one per poll.
// A two-entry command queue lets the front end take items while the back end shifts.
// Reset (rst_n, asynchronous, active low) sets phase idle, byte count zero,
// held data bit zero, image_length 163840 and trailing_clocks 19.
// ---------------------------------------------------------------------------
// fpga_passive_serial_loader_top
// Master side of a passive serial FPGA configuration load.
// ---------------------------------------------------------------------------
module fpga_passive_serial_loader_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [fpsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: pulse_reset, data_byte[7:0], status_pin, done_pin, zero fill.
    input  logic [fpsl_pkg::IN_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: reset_line, clock_pulse, data_bit, load_status[2:0], zero fill.
    output logic [fpsl_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import fpsl_pkg::*;

    logic    q_full;
    logic    q_push;
    cmd_t    push_cmd;
    logic    q_pop;
    logic    q_valid;
    cmd_t    head_cmd;
    result_t result;

    // Front end: classification and load phase.
    fpsl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (s_tuser),
        .pulse_reset (s_tdata[0]),
        .data_byte   (s_tdata[8:1]),
        .status_pin  (s_tdata[9]),
        .done_pin    (s_tdata[10]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // Command queue.
    fpsl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: pin sequencer.
    fpsl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Output packing.
    assign m_tdata = {2'b00, result.load_status, result.data_bit,
                      result.clock_pulse, result.reset_line};
    assign m_tlast = result.last;

    // A rejected item never clocks the device and always ends its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[5:3] == ST_REJECT)) |-> (!m_tdata[1] && m_tlast))
        else $error("rejected result carries a clock or is not last");

    // The low half of a reset pulse is never clocked and never ends a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (!m_tdata[1] && !m_tlast))
        else $error("reset pulse low half malformed");

    // A status beyond the defined codes never reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:3] <= ST_REJECT))
        else $error("undefined load status");

endmodule

### bench/fpga_passive_serial_loader_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpga_passive_serial_loader_top_tb
// Self-checking bench for the passive serial configuration loader. Load
// commands go in over the input stream. A cycle-free model of the loader
// predicts the pin sequence that each command should produce, and every
// transfer on the output stream is checked against it in order. A directed
// pass covers the corner cases. A long back-pressure hold fills the block.
// Random load sequences with random register settings and stray commands
// finish the run, with random gaps on both sides.
// ---------------------------------------------------------------------------
module fpga_passive_serial_loader_top_tb;

    import fpsl_pkg::*;

    // Function code that the loader has no use for; it must be rejected.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int ITEM_TARGET   = 460;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_addr  = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [1:0]             s_tuser   = FUNC_START;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    // Bench control: calm turns off random gaps, a toggle of hold_req
    // starts one long receiver hold-off.
    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // Model state and register copies.
    phase_t             ld_phase     = PH_IDLE;
    logic [LEN_W-1:0]   bytes_done   = '0;
    logic               held_bit     = 1'b0;
    logic [LEN_W-1:0]   img_len      = LEN_RESET;
    logic [TRAIL_W-1:0] trail_clocks = TRAIL_RESET;

    result_t pending_pins[$];
    result_t want_pin;
    int      fail_count = 0;
    int      items_sent = 0;

    fpga_passive_serial_loader_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    // Queue one expected pin state.
    function automatic void add_pin(logic rl, logic ck, logic dbit, load_status_t st,
                                    logic lst);
        result_t r;
        r.reset_line  = rl;
        r.clock_pulse = ck;
        r.data_bit    = dbit;
        r.load_status = st;
        r.last        = lst;
        pending_pins.push_back(r);
    endfunction

    // Work out the pin states that one accepted command produces.
    function automatic void predict_pins(logic [1:0] func_code, logic pulse, logic [7:0] dbyte,
                                         logic sts_pin, logic done_pin);
        logic [LEN_W-1:0]   limit;
        logic [TRAIL_W-1:0] n_trail;
        load_status_t       fin_st;
        if (func_code == FUNC_START)
        begin
            bytes_done = '0;
            if (pulse)
                add_pin(1'b0, 1'b0, held_bit, ST_WORKING, 1'b0);
            if (pulse && !sts_pin)
            begin
                ld_phase = PH_WAIT;
                add_pin(1'b1, 1'b0, held_bit, ST_WAITING, 1'b1);
            end
            else
            begin
                ld_phase = PH_LOAD;
                add_pin(1'b1, 1'b0, held_bit, ST_WORKING, 1'b1);
            end
        end
        else if (func_code == FUNC_POLL && ld_phase == PH_WAIT)
        begin
            if (sts_pin)
            begin
                ld_phase = PH_LOAD;
                add_pin(1'b1, 1'b0, held_bit, ST_WORKING, 1'b1);
            end
            else
                add_pin(1'b1, 1'b0, held_bit, ST_WAITING, 1'b1);
        end
        else if (func_code == FUNC_BYTE && ld_phase == PH_LOAD)
        begin
            // A zero length behaves as a one-byte image.
            limit      = (img_len == '0) ? LEN_W'(1) : img_len;
            n_trail    = (trail_clocks > MAX_TRAIL) ? MAX_TRAIL : trail_clocks;
            bytes_done = bytes_done + 1'b1;
            // An error on the status pin wins over done, done wins over the length.
            if (!sts_pin)
            begin
                fin_st   = ST_ERROR;
                ld_phase = PH_ERROR;
            end
            else if (done_pin)
            begin
                fin_st   = ST_DONE;
                ld_phase = PH_DONE;
            end
            else if (bytes_done >= limit)
            begin
                fin_st   = ST_ENDED;
                ld_phase = PH_ENDED;
            end
            else
                fin_st = ST_WORKING;
            for (int i = 0; i < 8; i++)
            begin
                held_bit = dbyte[i];
                add_pin(1'b1, 1'b1, held_bit, (i == 7) ? fin_st : ST_WORKING,
                        (i == 7) && !(fin_st == ST_DONE && n_trail != '0));
            end
            if (fin_st == ST_DONE)
                for (int i = 0; i < n_trail; i++)
                    add_pin(1'b1, 1'b1, held_bit, ST_DONE, i == n_trail - 1);
        end
        else
            add_pin(1'b1, 1'b0, held_bit, ST_REJECT, 1'b1);
    endfunction

    // Offer one command until it is transferred, with an occasional gap first.
    task automatic send_item(input logic [1:0] func_code, input logic pulse,
                             input logic [7:0] dbyte, input logic sts_pin,
                             input logic done_pin);
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func_code;
        s_tdata  <= {5'b0, done_pin, sts_pin, dbyte, pulse};
        do
            @(posedge clk);
        while (!s_tready);
        predict_pins(func_code, pulse, dbyte, sts_pin, done_pin);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted pin state has been seen.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= reg_idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (reg_idx == CFG_IMAGE_LENGTH)
            img_len = value[LEN_W-1:0];
        else
            trail_clocks = value[TRAIL_W-1:0];
        @(posedge clk);
    endtask

    // Rejections, each phase change other than ending on the image length, and both data byte extremes.
    task automatic test_directed();
        send_item(FUNC_POLL,  1'b1, 8'h00, 1'b1, 1'b1);
        send_item(FUNC_BYTE,  1'b0, 8'hFF, 1'b1, 1'b0);
        send_item(FUNC_NONE,  1'b1, 8'hFF, 1'b0, 1'b1);
        send_item(FUNC_START, 1'b0, 8'h00, 1'b0, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b1, 8'hFF, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'hA5, 1'b1, 1'b1);
        send_item(FUNC_BYTE,  1'b0, 8'h12, 1'b1, 1'b0);
        send_item(FUNC_START, 1'b1, 8'h00, 1'b0, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h77, 1'b1, 1'b0);
        send_item(FUNC_POLL,  1'b0, 8'h00, 1'b0, 1'b0);
        send_item(FUNC_POLL,  1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_POLL,  1'b0, 8'h00, 1'b1, 1'b0);
        // Status low together with done: the error takes priority.
        send_item(FUNC_BYTE,  1'b0, 8'h3C, 1'b0, 1'b1);
        send_item(FUNC_POLL,  1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_START, 1'b1, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h81, 1'b1, 1'b0);
        // Restart in the middle of a load.
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h5A, 1'b1, 1'b0);
        send_item(FUNC_NONE,  1'b0, 8'h00, 1'b1, 1'b0);
    endtask

    // Register extremes: zero and one byte images, no trailing clocks,
    // the full count, a saturated count and an image length of 16777216.
    task automatic test_config_extremes();
        settle();
        write_reg(CFG_IMAGE_LENGTH, '0);
        write_reg(CFG_TRAILING_CLOCKS, '0);
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'hC3, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h3C, 1'b1, 1'b0);
        send_item(FUNC_START, 1'b1, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h96, 1'b1, 1'b1);
        settle();
        write_reg(CFG_IMAGE_LENGTH, 25'd1);
        write_reg(CFG_TRAILING_CLOCKS, 25'd32);
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h01, 1'b1, 1'b1);
        settle();
        write_reg(CFG_TRAILING_CLOCKS, 25'd63);
        write_reg(CFG_IMAGE_LENGTH, 25'd2);
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h80, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h7F, 1'b1, 1'b0);
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'hE7, 1'b1, 1'b1);
        settle();
        write_reg(CFG_IMAGE_LENGTH, 25'd16777216);
        write_reg(CFG_TRAILING_CLOCKS, 25'd1);
        send_item(FUNC_START, 1'b1, 8'h00, 1'b1, 1'b0);
        repeat (3) send_item(FUNC_BYTE, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        send_item(FUNC_BYTE,  1'b0, 8'h18, 1'b1, 1'b1);
    endtask

    // Receiver holds off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        settle();
        write_reg(CFG_IMAGE_LENGTH, 25'd100);
        calm     <= 1'b1;
        hold_req <= ~hold_req;
        send_item(FUNC_START, 1'b0, 8'h00, 1'b1, 1'b0);
        repeat (30) send_item(FUNC_BYTE, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        calm <= 1'b0;
    endtask

    // Mostly well-formed loads with random content, plus stray commands and
    // new register settings now and then.
    task automatic test_random_loads(input int target);
        int  loads;
        int  n_bytes;
        logic pulse;
        loads = 0;
        while (items_sent < target)
        begin
            if (loads % 6 == 5)
            begin
                settle();
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_IMAGE_LENGTH, '0);
                    1:       write_reg(CFG_IMAGE_LENGTH, 25'd1);
                    2:       write_reg(CFG_IMAGE_LENGTH, 25'd16777216);
                    3:       write_reg(CFG_IMAGE_LENGTH, CFG_DATA_W'($urandom()));
                    default: write_reg(CFG_IMAGE_LENGTH, CFG_DATA_W'($urandom_range(2, 24)));
                endcase
                write_reg(CFG_TRAILING_CLOCKS, CFG_DATA_W'($urandom_range(0, 63)));
            end
            loads++;
            if ($urandom_range(0, 99) < 15)
                send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else
            begin
                pulse = 1'($urandom_range(0, 1));
                send_item(FUNC_START, pulse, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 2) != 0), 1'($urandom_range(0, 1)));
                while (ld_phase == PH_WAIT)
                    send_item(FUNC_POLL, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 2) == 0), 1'($urandom_range(0, 1)));
                n_bytes = $urandom_range(1, 30);
                while (n_bytes > 0 && ld_phase == PH_LOAD)
                begin
                    send_item(FUNC_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 39) != 0), 1'($urandom_range(0, 24) == 0));
                    n_bytes--;
                end
                // Sometimes a byte arrives after the load is over.
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_BYTE, 1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pins.size() == 0)
            begin
                $error("unexpected transfer: tdata %h, tlast %b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want_pin = pending_pins.pop_front();
                if (m_tdata[0] !== want_pin.reset_line)
                begin
                    $error("reset_line: expected %0d, got %0d", want_pin.reset_line, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[1] !== want_pin.clock_pulse)
                begin
                    $error("clock_pulse: expected %0d, got %0d", want_pin.clock_pulse,
                           m_tdata[1]);
                    fail_count++;
                end
                if (m_tdata[2] !== want_pin.data_bit)
                begin
                    $error("data_bit: expected %0d, got %0d", want_pin.data_bit, m_tdata[2]);
                    fail_count++;
                end
                if (m_tdata[5:3] !== want_pin.load_status)
                begin
                    $error("load_status: expected %0d, got %0d", want_pin.load_status,
                           m_tdata[5:3]);
                    fail_count++;
                end
                if (m_tlast !== want_pin.last)
                begin
                    $error("last: expected %0d, got %0d", want_pin.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        // A stretch with no gaps on either side.
        calm <= 1'b1;
        test_random_loads(items_sent + 60);
        calm <= 1'b0;
        test_random_loads(ITEM_TARGET);
        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("fpga_passive_serial_loader_top_tb OK");
        else
            $display("fpga_passive_serial_loader_top_tb NOT OK");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("fpga_passive_serial_loader_top_tb NOT OK");
        $finish;
    end

endmodule

### sim.f
hdl/fpsl_pkg.sv
hdl/fpsl_front.sv
hdl/fpsl_queue.sv
hdl/fpsl_back.sv
hdl/fpga_passive_serial_loader_top.sv
bench/fpga_passive_serial_loader_top_tb.sv
